// ===== rtl/mbwp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI byte packer package
// Shared types and MIDI status constants for the byte-to-word packer.
// ----------------------------------------------------------------------------
package mbwp_pkg;

  localparam int DefMaxPorts = 16;

  localparam logic [7:0] ST_CHANNEL_BASE   = 8'h80;
  localparam logic [7:0] ST_SYSEX          = 8'hf0;
  localparam logic [7:0] ST_SYSEX_END      = 8'hf7;
  localparam logic [7:0] ST_LAST_WITH_DATA = 8'hf3;
  localparam logic [7:0] ST_PROGRAM        = 8'hc0;
  localparam logic [7:0] ST_CHAN_PRESSURE  = 8'hd0;
  localparam logic [7:0] ST_TIMECODE       = 8'hf1;
  localparam logic [7:0] HIGH_NIBBLE_MASK  = 8'hf0;

  typedef struct packed {
    logic [3:0] port_number;
    logic [7:0] midi_byte;
  } item_t;

  typedef struct packed {
    logic [3:0]  out_port;
    logic [31:0] packed_word;
  } result_t;

endpackage

// ===== rtl/mbwp_in_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI byte packer input register
// Holds one incoming beat until the framer takes it.
// ----------------------------------------------------------------------------
module mbwp_in_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  mbwp_pkg::item_t in_item,
  output logic           out_valid,
  input  logic           out_ready,
  output mbwp_pkg::item_t out_item
);
  import mbwp_pkg::*;

  logic  valid;
  item_t item;

  // The register refills in the same cycle as it is drained.
  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= in_item;
    end
  end

endmodule

// ===== rtl/mbwp_framer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI byte packer framer
// Running-status framing state, word assembly and the result register.
// ----------------------------------------------------------------------------
module mbwp_framer #(
  parameter int MAX_PORTS = mbwp_pkg::DefMaxPorts
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [4:0]       open_ports,
  input  logic             in_valid,
  output logic             in_ready,
  input  mbwp_pkg::item_t  in_item,
  output logic             out_valid,
  input  logic             out_ready,
  output mbwp_pkg::result_t out_result
);
  import mbwp_pkg::*;

  localparam logic [4:0] PortLimit = (MAX_PORTS > 16) ? 5'd16 : 5'(MAX_PORTS);

  logic [7:0] held [4];
  logic [1:0] held_count;
  logic       in_sysex;

  logic [7:0] held_next [4];
  logic [1:0] held_count_next;
  logic       in_sysex_next;
  logic       emit;
  logic [7:0] word_bytes [4];

  logic       valid;
  result_t    result;

  logic       consume;
  logic       port_ok;
  logic [7:0] b;
  logic [7:0] status;
  logic       chan_status;

  assign in_ready   = !valid || out_ready;
  assign consume    = in_valid && in_ready;
  assign out_valid  = valid;
  assign out_result = result;

  assign b           = in_item.midi_byte;
  assign port_ok     = ({1'b0, in_item.port_number} < open_ports) &&
                       ({1'b0, in_item.port_number} < PortLimit);
  assign status      = (held[0] < ST_SYSEX) ? (held[0] & HIGH_NIBBLE_MASK) : held[0];
  assign chan_status = status < ST_SYSEX;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      held_next[i]  = held[i];
      word_bytes[i] = 8'h00;
    end
    held_count_next = held_count;
    in_sysex_next   = in_sysex;
    emit            = 1'b0;

    if (!port_ok) begin
      emit = 1'b0;
    end else if (b > ST_SYSEX_END) begin
      // Realtime bytes pass straight through without touching the framing.
      emit          = 1'b1;
      word_bytes[0] = b;
    end else if (b == ST_SYSEX) begin
      held_next[0]    = ST_SYSEX;
      held_count_next = 2'd1;
      in_sysex_next   = 1'b1;
    end else if (b == ST_SYSEX_END) begin
      for (int i = 0; i < 4; i++) begin
        if (2'(i) < held_count) begin
          held_next[i] = held[i];
        end else if (2'(i) == held_count) begin
          held_next[i] = ST_SYSEX_END;
        end else begin
          held_next[i] = 8'h00;
        end
        word_bytes[i] = held_next[i];
      end
      held_count_next = 2'd0;
      in_sysex_next   = 1'b0;
      emit            = 1'b1;
    end else if (b >= ST_CHANNEL_BASE) begin
      in_sysex_next = 1'b0;
      if (b > ST_LAST_WITH_DATA) begin
        held_count_next = 2'd0;
        emit            = 1'b1;
        word_bytes[0]   = b;
      end else begin
        held_next[0]    = b;
        held_count_next = 2'd1;
      end
    end else if (in_sysex) begin
      held_next[held_count] = b;
      if (held_count == 2'd3) begin
        held_count_next = 2'd0;
        emit            = 1'b1;
        for (int i = 0; i < 4; i++) begin
          word_bytes[i] = held_next[i];
        end
      end else begin
        held_count_next = held_count + 2'd1;
      end
    end else if (held_count == 2'd0) begin
      // A data byte with no status to belong to is dropped.
      emit = 1'b0;
    end else if (status == ST_PROGRAM || status == ST_CHAN_PRESSURE ||
                 status == ST_TIMECODE || status == ST_LAST_WITH_DATA) begin
      held_count_next = chan_status ? 2'd1 : 2'd0;
      emit            = 1'b1;
      word_bytes[0]   = held[0];
      word_bytes[1]   = b;
    end else if (held_count == 2'd1) begin
      held_next[1]    = b;
      held_count_next = 2'd2;
    end else begin
      held_count_next = chan_status ? 2'd1 : 2'd0;
      emit            = 1'b1;
      word_bytes[0]   = held[0];
      word_bytes[1]   = held[1];
      word_bytes[2]   = b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        held[i] <= 8'h00;
      end
      held_count <= 2'd0;
      in_sysex   <= 1'b0;
      valid      <= 1'b0;
    end else begin
      if (consume) begin
        held       <= held_next;
        held_count <= held_count_next;
        in_sysex   <= in_sysex_next;
      end
      if (in_ready) begin
        valid <= consume && emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (consume && emit) begin
      result.packed_word <= {word_bytes[3], word_bytes[2], word_bytes[1], word_bytes[0]};
      result.out_port    <= in_item.port_number;
    end
  end

endmodule

// ===== rtl/midi_byte_to_word_packer.sv =====
`timescale 1ns / 1ps
// A word passes the input register, then the result register behind the
// framing logic, on its way out.
// Throughput: one MIDI byte per cycle unless m_tready stalls the output; the
// one-byte framing update is the only logic between the two registers.
// Reset (rst, synchronous): framing state, open_ports and both valid flags clear.
// ----------------------------------------------------------------------------
// MIDI byte to word packer
// Frames MIDI bytes into messages and emits each as a 32-bit word.
// ----------------------------------------------------------------------------
module midi_byte_to_word_packer #(
  parameter int MAX_PORTS = mbwp_pkg::DefMaxPorts
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [4:0]  cfg_wr_data,  // open_ports
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,      // midi_byte[7:0], port_number[11:8], zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata       // packed_word[31:0], out_port[35:32], zero pad
);
  import mbwp_pkg::*;

  logic [4:0] open_ports;
  item_t      s_item;
  item_t      f_item;
  logic       f_valid;
  logic       f_ready;
  result_t    m_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      open_ports <= 5'd0;
    end else if (cfg_wr_en) begin
      open_ports <= cfg_wr_data;
    end
  end

  assign s_item.midi_byte   = s_tdata[7:0];
  assign s_item.port_number = s_tdata[11:8];

  mbwp_in_reg u_in_reg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_item   (s_item),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_item  (f_item)
  );

  mbwp_framer #(
    .MAX_PORTS (MAX_PORTS)
  ) u_framer (
    .clk        (clk),
    .rst        (rst),
    .open_ports (open_ports),
    .in_valid   (f_valid),
    .in_ready   (f_ready),
    .in_item    (f_item),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_result (m_result)
  );

  assign m_tdata = {4'h0, m_result.out_port, m_result.packed_word};

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI byte to word packer testbench
// Drives MIDI byte beats with port numbers into the packer and checks every
// packed word against a cycle-free framing predictor kept in a scoreboard.
// The run mixes directed messages with random framed traffic, noise, closed
// ports and several open-port settings, with random idling on both streams.
// ----------------------------------------------------------------------------
module tb;
  import mbwp_pkg::*;

  localparam int MAX_PORTS = DefMaxPorts;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES = 80;
  localparam int WATCHDOG_LIMIT = 2000;

  localparam logic [7:0] NOTE_OFF       = 8'h80;
  localparam logic [7:0] NOTE_ON        = 8'h90;
  localparam logic [7:0] POLY_PRESSURE  = 8'ha0;
  localparam logic [7:0] CONTROL_CHANGE = 8'hb0;
  localparam logic [7:0] PITCH_BEND     = 8'he0;
  localparam logic [7:0] SONG_POSITION  = 8'hf2;
  localparam logic [7:0] SINGLE_FIRST   = 8'hf4;
  localparam logic [7:0] TUNE_REQUEST   = 8'hf6;
  localparam logic [7:0] RT_CLOCK       = 8'hf8;
  localparam logic [7:0] RT_START       = 8'hfa;
  localparam logic [7:0] RT_RESET       = 8'hff;
  localparam logic [7:0] DATA_MAX       = 8'h7f;

  class word_scoreboard;
    logic [4:0] open_ports;
    logic [7:0] held [4];
    logic [1:0] held_count;
    bit         in_sysex;
    result_t    expected_words [$];
    int         errors;
    int         checked;

    function new();
      open_ports = '0;
      held_count = '0;
      in_sysex = 1'b0;
      errors = 0;
      checked = 0;
      foreach (held[i]) held[i] = '0;
    endfunction

    function void set_open_ports(logic [4:0] value);
      open_ports = value;
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    // Frames one byte; returns 1 when the byte completes a word.
    function bit frame_byte(logic [7:0] b, logic [3:0] p, output result_t word);
      logic [7:0] status;
      word.out_port = p;
      word.packed_word = '0;
      if ({1'b0, p} >= open_ports || int'(p) >= MAX_PORTS) return 1'b0;
      if (b > ST_SYSEX_END) begin
        word.packed_word = {24'h0, b};
        return 1'b1;
      end
      if (b == ST_SYSEX) begin
        held[0] = ST_SYSEX;
        held_count = 2'd1;
        in_sysex = 1'b1;
        return 1'b0;
      end
      if (b == ST_SYSEX_END) begin
        held[held_count] = b;
        for (int i = int'(held_count) + 1; i < 4; i++) held[i] = '0;
        held_count = '0;
        in_sysex = 1'b0;
        word.packed_word = {held[3], held[2], held[1], held[0]};
        return 1'b1;
      end
      if (b >= ST_CHANNEL_BASE) begin
        in_sysex = 1'b0;
        if (b > ST_LAST_WITH_DATA) begin
          held_count = '0;
          word.packed_word = {24'h0, b};
          return 1'b1;
        end
        held[0] = b;
        held_count = 2'd1;
        return 1'b0;
      end
      if (in_sysex) begin
        held[held_count] = b;
        if (held_count == 2'd3) begin
          held_count = '0;
          word.packed_word = {held[3], held[2], held[1], held[0]};
          return 1'b1;
        end
        held_count = held_count + 2'd1;
        return 1'b0;
      end
      // A data byte with nothing held has no status to belong to.
      if (held_count == '0) return 1'b0;
      status = held[0];
      if (status < ST_SYSEX) status = status & HIGH_NIBBLE_MASK;
      if (status == ST_PROGRAM || status == ST_CHAN_PRESSURE ||
          status == ST_TIMECODE || status == ST_LAST_WITH_DATA) begin
        held_count = (status < ST_SYSEX) ? 2'd1 : 2'd0;
        word.packed_word = {16'h0, b, held[0]};
        return 1'b1;
      end
      if (held_count == 2'd1) begin
        held[1] = b;
        held_count = 2'd2;
        return 1'b0;
      end
      held_count = (status < ST_SYSEX) ? 2'd1 : 2'd0;
      word.packed_word = {8'h0, b, held[1], held[0]};
      return 1'b1;
    endfunction

    function void note_byte(item_t beat);
      result_t word;
      if (frame_byte(beat.midi_byte, beat.port_number, word))
        expected_words.push_back(word);
    endfunction

    function void check_word(result_t got);
      result_t want;
      if (expected_words.size() == 0) begin
        $error("unexpected word %h on port %0d", got.packed_word, got.out_port);
        errors++;
        return;
      end
      want = expected_words.pop_front();
      checked++;
      if (got.packed_word !== want.packed_word) begin
        $error("packed_word: expected %h, got %h", want.packed_word, got.packed_word);
        errors++;
      end
      if (got.out_port !== want.out_port) begin
        $error("out_port: expected %0d, got %0d", want.out_port, got.out_port);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [4:0]  cfg_wr_data;   // open_ports
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;       // midi_byte[7:0], port_number[11:8], zero pad
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;       // packed_word[31:0], out_port[35:32], zero pad

  word_scoreboard sb = new();

  bit tx_gaps;
  bit rx_stalls;
  bit hold_req;
  int hold_left;
  int quiet_cycles;
  int beats_sent;
  int open_beats;
  int settings_used;

  midi_byte_to_word_packer #(
    .MAX_PORTS(MAX_PORTS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Receiver: random stalls, plus a long hold-off counted here on request.
  initial begin
    m_tready = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= !rx_stalls || ($urandom_range(99) >= 33);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_word(result_t'(m_tdata[35:0]));
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL midi_byte_to_word_packer");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_byte(logic [7:0] b, logic [3:0] p);
    @(negedge clk);
    // Each cycle before the beat is offered idles with a chance of one in three.
    while (tx_gaps && $urandom_range(99) < 33) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {4'h0, p, b};
    do @(posedge clk); while (!s_tready);
    sb.note_byte(item_t'({p, b}));
    beats_sent++;
    if ({1'b0, p} < sb.open_ports) open_beats++;
  endtask

  task automatic stop_sending();
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  // Waits for every expected word, then lets any word-less beat leave the pipe.
  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_open_ports(logic [4:0] value);
    stop_sending();
    wait_drained();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_open_ports(value);
    settings_used++;
  endtask

  function automatic logic [3:0] pick_port();
    int open;
    open = (int'(sb.open_ports) > MAX_PORTS) ? MAX_PORTS : int'(sb.open_ports);
    if (open == 0 || $urandom_range(9) == 0) return 4'($urandom_range(0, 15));
    return 4'($urandom_range(0, open - 1));
  endfunction

  task automatic send_data();
    if ($urandom_range(99) < 6) send_byte(8'($urandom_range(RT_CLOCK, RT_RESET)), pick_port());
    send_byte(8'($urandom_range(0, DATA_MAX)), pick_port());
  endtask

  task automatic send_random_message();
    logic [7:0] two_byte_ops [5];
    logic [7:0] st;
    int pick;
    two_byte_ops = '{NOTE_OFF, NOTE_ON, POLY_PRESSURE, CONTROL_CHANGE, PITCH_BEND};
    pick = $urandom_range(99);
    if (pick < 30) begin
      st = two_byte_ops[$urandom_range(0, 4)] | 8'($urandom_range(0, 15));
      send_byte(st, pick_port());
      repeat ($urandom_range(1, 3)) begin
        send_data();
        send_data();
      end
    end else if (pick < 44) begin
      st = ($urandom_range(1) ? ST_PROGRAM : ST_CHAN_PRESSURE) | 8'($urandom_range(0, 15));
      send_byte(st, pick_port());
      repeat ($urandom_range(1, 3)) send_data();
    end else if (pick < 54) begin
      st = 8'($urandom_range(ST_TIMECODE, ST_LAST_WITH_DATA));
      send_byte(st, pick_port());
      send_data();
      if (st == SONG_POSITION) send_data();
    end else if (pick < 60) begin
      send_byte(8'($urandom_range(SINGLE_FIRST, TUNE_REQUEST)), pick_port());
    end else if (pick < 67) begin
      send_byte(8'($urandom_range(RT_CLOCK, RT_RESET)), pick_port());
    end else if (pick < 84) begin
      send_byte(ST_SYSEX, pick_port());
      repeat ($urandom_range(0, 10)) send_data();
      if ($urandom_range(9) != 0) send_byte(ST_SYSEX_END, pick_port());
    end else if (pick < 92) begin
      // Cut-short message or stray data with whatever status is left over.
      if ($urandom_range(1)) send_byte(two_byte_ops[$urandom_range(0, 4)], pick_port());
      send_data();
    end else begin
      send_byte(8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));
    end
  endtask

  task automatic run_random(int count);
    int start;
    start = open_beats;
    while (open_beats - start < count) send_random_message();
  endtask

  initial begin
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    tx_gaps = 1'b1;
    rx_stalls = 1'b1;
    hold_req = 1'b0;
    quiet_cycles = 0;
    beats_sent = 0;
    open_beats = 0;
    settings_used = 1;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // Out of reset no port is open, so every beat is ignored.
    repeat (12) send_byte(8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));

    write_open_ports(5'd16);
    send_byte(RT_CLOCK, 4'd0);
    send_byte(RT_RESET, 4'd15);
    send_byte(8'h45, 4'd3);
    send_byte(ST_SYSEX_END, 4'd1);
    send_byte(NOTE_ON, 4'd2);
    send_byte(8'h00, 4'd2);
    send_byte(DATA_MAX, 4'd9);
    send_byte(ST_PROGRAM | 8'h05, 4'd15);
    send_byte(DATA_MAX, 4'd15);
    send_byte(8'h12, 4'd4);
    send_byte(ST_CHAN_PRESSURE, 4'd6);
    send_byte(8'h55, 4'd6);
    send_byte(ST_TIMECODE, 4'd7);
    send_byte(8'h23, 4'd7);
    send_byte(8'h10, 4'd7);
    send_byte(SONG_POSITION, 4'd8);
    send_byte(8'h01, 4'd8);
    send_byte(8'h02, 4'd8);
    send_byte(ST_LAST_WITH_DATA, 4'd10);
    send_byte(8'h05, 4'd10);
    send_byte(ST_SYSEX, 4'd11);
    send_byte(DATA_MAX, 4'd11);
    send_byte(8'h2a, 4'd11);
    send_byte(8'h6b, 4'd12);
    send_byte(8'h03, 4'd12);
    send_byte(RT_START, 4'd13);
    send_byte(ST_SYSEX_END, 4'd14);
    send_byte(SINGLE_FIRST, 4'd5);
    send_byte(TUNE_REQUEST, 4'd1);

    run_random(90);

    // Receiver holds off while the sender keeps offering realtime bytes.
    tx_gaps = 1'b0;
    rx_stalls = 1'b0;
    stop_sending();
    wait_drained();
    hold_req = 1'b1;
    repeat (40) send_byte(8'($urandom_range(RT_CLOCK, RT_RESET)), pick_port());
    stop_sending();
    wait_drained();
    tx_gaps = 1'b1;
    rx_stalls = 1'b1;

    write_open_ports(5'd1);
    run_random(50);

    // A long stretch with neither side idling.
    write_open_ports(5'd7);
    tx_gaps = 1'b0;
    rx_stalls = 1'b0;
    run_random(80);
    tx_gaps = 1'b1;
    rx_stalls = 1'b1;

    write_open_ports(5'd16);
    run_random(80);

    write_open_ports(5'd0);
    repeat (12) send_byte(8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));

    stop_sending();
    wait_drained();
    if (sb.pending() != 0) begin
      $error("%0d expected words never arrived", sb.pending());
      sb.errors++;
    end
    $display("Covered %0d MIDI beats (%0d on open ports) over %0d port settings,",
             beats_sent, open_beats, settings_used);
    $display("with %0d packed words checked and %0d mismatches.", sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("PASS midi_byte_to_word_packer");
    end else begin
      $display("FAIL midi_byte_to_word_packer");
    end
    $finish;
  end

endmodule
